// ===== sv/wos_pkg.sv =====
// ----------------------------------------------------------------------------
// wos_pkg: shared types and constants of the wheel odometry sampler
// Field widths, the log word layout, command codes and sequencer states.
// ----------------------------------------------------------------------------
package wos_pkg;

   // Probe log
   localparam int MAX_PROBE = 1023;
   localparam int LOG_DEPTH = 1024;
   localparam int LOG_AW    = $clog2(LOG_DEPTH);
   localparam int PROBE_CAP = (MAX_PROBE > LOG_DEPTH - 1) ? LOG_DEPTH - 1 : MAX_PROBE;

   // Field widths
   localparam int CNT_W   = 32;
   localparam int DELTA_W = 16;
   localparam int DIST_W  = 32;
   localparam int SPEED_W = 42;
   localparam int TOTAL_W = 48;
   localparam int PER_W   = 16;
   localparam int DPP_W   = 16;
   localparam int SCALE_W = 10;
   localparam int TICK_W  = 16;
   localparam int CSR_IW  = 2;
   localparam int CSR_DW  = 16;
   localparam int MUL_AW  = 32;
   localparam int MUL_BW  = 16;
   localparam int MUL_PW  = MUL_AW + MUL_BW;

   // Log word: left dist, right dist, left speed, right speed, mean (low bits first)
   localparam int LOG_W = 3 * DIST_W + 2 * SPEED_W;

   // Stream payload widths
   localparam int REQ_DW = 16;
   localparam int RSP_DW = 240;

   // Reset values of the registers
   localparam logic [PER_W-1:0]   PERIOD_RST = PER_W'(200);
   localparam logic [DPP_W-1:0]   DPP_RST    = DPP_W'(788);
   localparam logic [SCALE_W-1:0] SCALE_RST  = SCALE_W'(50);

   // Register indexes
   localparam logic [CSR_IW-1:0] REG_PERIOD = 2'd0;
   localparam logic [CSR_IW-1:0] REG_DPP    = 2'd1;
   localparam logic [CSR_IW-1:0] REG_SCALE  = 2'd2;

   typedef enum logic [1:0] {
      CMD_PULSE = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_READ   = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_TOTAL,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      CS_LD,
      CS_RD,
      CS_LS,
      CS_RS,
      CS_MEAN
   } calc_step_type;

   // Results of one sample computation
   typedef struct packed {
      logic [DIST_W-1:0]  mean;
      logic [SPEED_W-1:0] rs;
      logic [SPEED_W-1:0] ls;
      logic [DIST_W-1:0]  rd;
      logic [DIST_W-1:0]  ld;
   } sample_type;

endpackage

// ===== sv/wheel_odometry_sampler_top.sv =====
// ----------------------------------------------------------------------------
// wheel_odometry_sampler_top: wheel odometry sampler
// Pulse counting, sample period timing, sample arithmetic and the probe log.
// ----------------------------------------------------------------------------
// Pulse, clear and non-sampling tick words are taken without leaving idle. A log
// read holds the request side while the accept cycle starts the registered read
// of the log memory, the read state passes and the emit state loads the
// response register. A tick that ends a period holds it through the accept, the
// five sequencer steps (left and right distance, left and right speed on the
// single shared 32x16 multiplier, then the mean), the registered done flag
// reaching the control, the running total and the log write, and the load of
// the response register. Reads and samples wait longer while the previous
// response still occupies the output register.
// A new request word is taken as soon as the block is back in idle, even while
// the previous response still waits in its output register; a second response
// waits until that register is free. The log memory is not cleared: reading an
// entry that no sample has written returns arbitrary data.
// ----------------------------------------------------------------------------
module wheel_odometry_sampler_top (
   input  logic                          clock,
   input  logic                          reset,
   // Request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [wos_pkg::REQ_DW-1:0]    req_tdata,  // wheel[0], log_index[10:1], zero fill
   input  logic [1:0]                    req_tuser,  // command[1:0]
   // Response stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // probe_index[9:0], left_distance[41:10], right_distance[73:42],
   // left_speed[115:74], right_speed[157:116], mean_distance[189:158],
   // total_distance[237:190], zero fill
   output logic [wos_pkg::RSP_DW-1:0]    rsp_tdata,
   output logic                          rsp_tuser,  // kind[0]
   // Register write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wos_pkg::CSR_IW-1:0]    csr_index,
   input  logic [wos_pkg::CSR_DW-1:0]    csr_data
);
   import wos_pkg::*;

   // Registers
   logic [PER_W-1:0]    period_ff;
   logic [DPP_W-1:0]    dpp_ff;
   logic [SCALE_W-1:0]  scale_ff;

   // Block state
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    left_cnt_ff, right_cnt_ff;
   logic [CNT_W-1:0]    left_prev_ff, right_prev_ff;
   logic [TICK_W-1:0]   ticks_ff;
   logic [LOG_AW-1:0]   probe_ff;
   logic [TOTAL_W-1:0]  total_ff;

   // Pending work
   logic [DELTA_W-1:0]  left_delta_ff, right_delta_ff;
   logic [LOG_AW-1:0]   index_ff;
   kind_type            kind_ff;

   // Response register
   logic                rsp_valid_ff;
   kind_type            rsp_kind_ff;
   logic [LOG_AW-1:0]   rsp_index_ff;
   sample_type          rsp_data_ff;
   logic [TOTAL_W-1:0]  rsp_total_ff;

   // Decoded request word
   cmd_type             cmd;
   logic                wheel;
   logic [LOG_AW-1:0]   log_index;
   logic                accept;
   logic [TICK_W:0]     ticks_next;
   logic                take_sample;
   logic [CNT_W-1:0]    left_diff, right_diff;

   logic                calc_start;
   logic                calc_done;
   sample_type          calc_res;
   logic                log_wr;
   logic                log_rd;
   logic [LOG_W-1:0]    log_q;
   sample_type          log_entry;
   logic                emit_load;

   assign cmd       = cmd_type'(req_tuser);
   assign wheel     = req_tdata[0];
   assign log_index = req_tdata[LOG_AW:1];
   assign accept    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   assign ticks_next  = {1'b0, ticks_ff} + (TICK_W + 1)'(1);
   assign take_sample = accept && (cmd == CMD_TICK) && (ticks_next > {1'b0, period_ff});
   assign left_diff   = left_cnt_ff - left_prev_ff;
   assign right_diff  = right_cnt_ff - right_prev_ff;

   assign calc_start = take_sample;
   assign log_wr     = (state_ff == ST_TOTAL);
   assign log_rd     = accept && (cmd == CMD_READ);
   assign log_entry  = sample_type'(log_q);
   assign emit_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   // Register writes: always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RST;
         dpp_ff    <= DPP_RST;
         scale_ff  <= SCALE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_PERIOD: period_ff <= csr_data;
            REG_DPP:    dpp_ff    <= csr_data;
            REG_SCALE:  scale_ff  <= csr_data[SCALE_W-1:0];
            default:    period_ff <= period_ff;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take_sample) begin
               state_in = ST_CALC;
            end else if (log_rd) begin
               state_in = ST_READ;
            end
         end
         ST_CALC: begin
            if (calc_done) begin
               state_in = ST_TOTAL;
            end
         end
         ST_TOTAL: state_in = ST_EMIT;
         ST_READ:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Counters, period timer, probe index and running total
   always_ff @(posedge clock) begin
      if (reset) begin
         left_cnt_ff   <= '0;
         right_cnt_ff  <= '0;
         left_prev_ff  <= '0;
         right_prev_ff <= '0;
         ticks_ff      <= '0;
         probe_ff      <= '0;
         total_ff      <= '0;
      end else begin
         if (accept) begin
            case (cmd)
               CMD_PULSE: begin
                  if (wheel) begin
                     left_cnt_ff <= left_cnt_ff + CNT_W'(1);
                  end else begin
                     right_cnt_ff <= right_cnt_ff + CNT_W'(1);
                  end
               end
               CMD_CLEAR: begin
                  left_cnt_ff   <= '0;
                  right_cnt_ff  <= '0;
                  left_prev_ff  <= '0;
                  right_prev_ff <= '0;
                  probe_ff      <= '0;
                  total_ff      <= '0;
               end
               CMD_TICK: begin
                  if (take_sample) begin
                     ticks_ff      <= '0;
                     left_prev_ff  <= left_cnt_ff;
                     right_prev_ff <= right_cnt_ff;
                  end else begin
                     ticks_ff <= ticks_next[TICK_W-1:0];
                  end
               end
               default: ticks_ff <= ticks_ff;
            endcase
         end
         // Add the mean and advance the probe index, holding at the cap
         if (state_ff == ST_TOTAL) begin
            total_ff <= total_ff + TOTAL_W'(calc_res.mean);
            if (probe_ff < LOG_AW'(PROBE_CAP)) begin
               probe_ff <= probe_ff + LOG_AW'(1);
            end else begin
               probe_ff <= LOG_AW'(PROBE_CAP);
            end
         end
      end
   end

   // Latch saturated deltas, log slot and response kind
   always_ff @(posedge clock) begin
      if (take_sample) begin
         left_delta_ff  <= (left_diff > CNT_W'(16'hFFFF)) ? 16'hFFFF : left_diff[DELTA_W-1:0];
         right_delta_ff <= (right_diff > CNT_W'(16'hFFFF)) ? 16'hFFFF
                                                             : right_diff[DELTA_W-1:0];
         index_ff       <= probe_ff;
         kind_ff        <= KIND_SAMPLE;
      end else if (log_rd) begin
         index_ff <= log_index;
         kind_ff  <= KIND_READ;
      end
   end

   wos_calc u_calc (
      .clock          (clock),
      .reset          (reset),
      .start          (calc_start),
      .left_delta     (left_delta_ff),
      .right_delta    (right_delta_ff),
      .dist_per_pulse (dpp_ff),
      .speed_scale    (scale_ff),
      .done           (calc_done),
      .result         (calc_res)
   );

   wos_ram #(
      .WIDTH (LOG_W),
      .DEPTH (LOG_DEPTH)
   ) u_log (
      .clock   (clock),
      .wr_en   (log_wr),
      .wr_addr (index_ff),
      .wr_data (LOG_W'(calc_res)),
      .rd_en   (log_rd),
      .rd_addr (log_index),
      .rd_data (log_q)
   );

   // Response register: load when free or being drained
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_kind_ff  <= kind_ff;
         rsp_index_ff <= index_ff;
         rsp_total_ff <= total_ff;
         rsp_data_ff  <= (kind_ff == KIND_READ) ? log_entry : calc_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {2'b00, rsp_total_ff, rsp_data_ff.mean, rsp_data_ff.rs,
                        rsp_data_ff.ls, rsp_data_ff.rd, rsp_data_ff.ld, rsp_index_ff};

endmodule

// ===== sv/wos_ram.sv =====
// ----------------------------------------------------------------------------
// wos_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wos_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/wos_calc.sv =====
// ----------------------------------------------------------------------------
// wos_calc: sample arithmetic sequencer
// Runs distances and speeds through one shared 32x16 multiplier, then the mean.
// ----------------------------------------------------------------------------
module wos_calc (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wos_pkg::DELTA_W-1:0]   left_delta,
   input  logic [wos_pkg::DELTA_W-1:0]   right_delta,
   input  logic [wos_pkg::DPP_W-1:0]     dist_per_pulse,
   input  logic [wos_pkg::SCALE_W-1:0]   speed_scale,
   output logic                          done,
   output wos_pkg::sample_type           result
);
   import wos_pkg::*;

   logic                busy_ff;
   logic                done_ff;
   calc_step_type       step_ff;
   logic [MUL_AW-1:0]   mul_a;
   logic [MUL_BW-1:0]   mul_b;
   logic [MUL_PW-1:0]   prod;
   logic [DIST_W:0]     dist_sum;
   sample_type          res_ff;

   // Select multiplier operands for the current step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         CS_LD: begin
            mul_a = MUL_AW'(left_delta);
            mul_b = MUL_BW'(dist_per_pulse);
         end
         CS_RD: begin
            mul_a = MUL_AW'(right_delta);
            mul_b = MUL_BW'(dist_per_pulse);
         end
         CS_LS: begin
            mul_a = res_ff.ld;
            mul_b = MUL_BW'(speed_scale);
         end
         CS_RS: begin
            mul_a = res_ff.rd;
            mul_b = MUL_BW'(speed_scale);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod     = MUL_PW'(mul_a) * MUL_PW'(mul_b);
   assign dist_sum = {1'b0, res_ff.ld} + {1'b0, res_ff.rd};

   // Sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= CS_LD;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= CS_LD;
         end else if (busy_ff) begin
            unique case (step_ff)
               CS_LD:   step_ff <= CS_RD;
               CS_RD:   step_ff <= CS_LS;
               CS_LS:   step_ff <= CS_RS;
               CS_RS:   step_ff <= CS_MEAN;
               CS_MEAN: begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
                  step_ff <= CS_LD;
               end
               default: step_ff <= CS_LD;
            endcase
         end
      end
   end

   // Capture each product, and then the mean, in its result register
   always_ff @(posedge clock) begin
      if (busy_ff && !start) begin
         case (step_ff)
            CS_LD:   res_ff.ld   <= prod[DIST_W-1:0];
            CS_RD:   res_ff.rd   <= prod[DIST_W-1:0];
            CS_LS:   res_ff.ls   <= prod[SPEED_W-1:0];
            CS_RS:   res_ff.rs   <= prod[SPEED_W-1:0];
            CS_MEAN: res_ff.mean <= dist_sum[DIST_W:1];
            default: res_ff      <= res_ff;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
